/* sv/lfbr_pkg.sv */
// ----------------------------------------------------------------------------
// lfbr_pkg
// Shared types and constants for the length framed byte receiver: status
// codes, configuration register indexes and the bundles passed between the
// top level and the frame tracker.
// ----------------------------------------------------------------------------
package lfbr_pkg;

    // Width of the frame position counter and of the reported position
    localparam int POS_W = 9;

    // Configuration register indexes
    localparam logic [1:0] REG_HEADER_FIRST    = 2'd0;
    localparam logic [1:0] REG_HEADER_SECOND   = 2'd1;
    localparam logic [1:0] REG_LENGTH_POSITION = 2'd2;

    // Reset value of the length field position
    localparam logic [3:0] LENGTH_POSITION_RST = 4'd4;

    // Frame status codes
    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_HEADER   = 2'd1,
        STATUS_BAD_CHECKSUM = 2'd2,
        STATUS_OVERFLOW     = 2'd3
    } status_t;

    // Configuration register set
    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [3:0] length_position;
    } cfg_t;

    // One result transaction
    typedef struct packed {
        logic             frame_end;
        status_t          frame_status;
        logic [7:0]       frame_len;
        logic [POS_W-1:0] byte_position;
    } result_t;

endpackage

/* sv/lfbr_frame_tracker.sv */
// ----------------------------------------------------------------------------
// lfbr_frame_tracker
// Frame state (position, length, running sum, header flag) and the single
// pass logic that classifies one received byte and builds its result.
// ----------------------------------------------------------------------------
module lfbr_frame_tracker #(
    parameter int BUF_BYTES = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  lfbr_pkg::cfg_t    cfg,
    output lfbr_pkg::result_t result
);

    localparam int POS_LIMIT = (BUF_BYTES < 512) ? BUF_BYTES : 512;
    localparam logic [lfbr_pkg::POS_W-1:0] POS_LAST = lfbr_pkg::POS_W'(POS_LIMIT - 1);

    logic [lfbr_pkg::POS_W-1:0] pos_reg;
    logic [lfbr_pkg::POS_W-1:0] pos_next;
    logic [7:0]                 length_reg;
    logic [7:0]                 length_next;
    logic [7:0]                 sum_reg;
    logic [7:0]                 sum_next;
    logic                       header_good_reg;
    logic                       header_good_next;

    logic [lfbr_pkg::POS_W-1:0] len_pos;
    logic [lfbr_pkg::POS_W-1:0] check_pos;
    logic                       frame_start;
    logic                       ends;
    lfbr_pkg::status_t          status;

    assign len_pos     = lfbr_pkg::POS_W'(cfg.length_position);
    assign check_pos   = len_pos + lfbr_pkg::POS_W'(length_reg);
    assign frame_start = (pos_reg == '0);

    // Per-byte classification
    always_comb
    begin
        // header check, cleared state at frame start
        if (frame_start)
        begin
            header_good_next = (rx_byte == cfg.header_first);
            length_next      = '0;
            sum_next         = '0;
        end
        else if (pos_reg == lfbr_pkg::POS_W'(1))
        begin
            header_good_next = header_good_reg && (rx_byte == cfg.header_second);
            length_next      = length_reg;
            sum_next         = sum_reg;
        end
        else
        begin
            header_good_next = header_good_reg;
            length_next      = length_reg;
            sum_next         = sum_reg;
        end

        ends   = 1'b0;
        status = lfbr_pkg::STATUS_OK;

        // length byte, summed range and checksum byte
        if (pos_reg == len_pos)
        begin
            length_next = rx_byte;
            sum_next    = rx_byte;
            if (rx_byte == 8'd0)
            begin
                ends   = 1'b1;
                status = header_good_next ? lfbr_pkg::STATUS_OK
                                          : lfbr_pkg::STATUS_BAD_HEADER;
            end
        end
        else if (pos_reg > len_pos)
        begin
            if (pos_reg == check_pos)
            begin
                ends = 1'b1;
                if (!header_good_next)
                    status = lfbr_pkg::STATUS_BAD_HEADER;
                else if (sum_reg != rx_byte)
                    status = lfbr_pkg::STATUS_BAD_CHECKSUM;
                else
                    status = lfbr_pkg::STATUS_OK;
            end
            else
            begin
                sum_next = sum_next + rx_byte;
            end
        end

        // buffer bound
        if (!ends && (pos_reg >= POS_LAST))
        begin
            ends   = 1'b1;
            status = lfbr_pkg::STATUS_OVERFLOW;
        end

        pos_next = ends ? '0 : pos_reg + lfbr_pkg::POS_W'(1);

        result.frame_end     = ends;
        result.frame_status  = status;
        result.frame_len     = length_next;
        result.byte_position = pos_reg;
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            length_reg      <= '0;
            sum_reg         <= '0;
            header_good_reg <= 1'b1;
        end
        else if (step)
        begin
            pos_reg         <= pos_next;
            length_reg      <= length_next;
            sum_reg         <= sum_next;
            header_good_reg <= header_good_next;
        end
    end

    // A frame end always restarts the position count
    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.frame_end |=> pos_reg == '0)
        else $error("position not cleared after frame end");

    // Position never passes the buffer bound
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("position beyond buffer bound");

    // Status is only non-ok on a frame end
    a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !result.frame_end |-> result.frame_status == lfbr_pkg::STATUS_OK)
        else $error("status set without frame end");

    // Without a frame end the position advances by one
    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        step && !result.frame_end |=> pos_reg == $past(pos_reg) + lfbr_pkg::POS_W'(1))
        else $error("position did not advance");

endmodule

/* sv/length_framed_byte_receiver.sv */
// ----------------------------------------------------------------------------
// length_framed_byte_receiver
// Deframer for header / length / sum-8 checksum framed byte streams.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event per transaction:
//   char_event marks a received character, rx_byte its value. Events with
//   char_event low are consumed and produce nothing.
//   Output channel (out_valid/out_ready) carries one transaction per
//   received character: frame_end, frame_status, frame_len and the
//   byte_position of that character.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
//   used only while no transaction is in flight.
//   Path: a transaction taken into the input register is classified by the
//   frame tracker, and its result is written into the output register,
//   which offers it on the output channel.
//   Throughput: one transaction per cycle while out_ready stays high, set
//   by the update of the frame state between input and output registers.
//   When out_ready is low the output register holds its result; the input
//   register takes transactions until it holds a character, then in_ready
//   drops. Reset clears the frame state (position 0, header flag set), the
//   valid flags of both pipeline registers and the configuration (headers 0, length at 4).
// ----------------------------------------------------------------------------
module length_framed_byte_receiver #(
    parameter int BUF_BYTES = 512
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [7:0]                 cfg_data,
    // input channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       char_event,
    input  logic [7:0]                 rx_byte,
    // output channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       frame_end,
    output logic [1:0]                 frame_status,
    output logic [7:0]                 frame_len,
    output logic [lfbr_pkg::POS_W-1:0] byte_position
);

    lfbr_pkg::cfg_t    cfg_reg;
    logic              in_valid_reg;
    logic              char_reg;
    logic [7:0]        byte_reg;
    logic              out_valid_reg;
    lfbr_pkg::result_t out_reg;
    lfbr_pkg::result_t result;
    logic              advance;
    logic              step;

    // Input register moves on when it is empty of a character or the
    // output register can take the result
    assign advance  = in_valid_reg && (!char_reg || !out_valid_reg || out_ready);
    assign step     = advance && char_reg;
    assign in_ready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first    <= '0;
            cfg_reg.header_second   <= '0;
            cfg_reg.length_position <= lfbr_pkg::LENGTH_POSITION_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lfbr_pkg::REG_HEADER_FIRST:    cfg_reg.header_first    <= cfg_data;
                lfbr_pkg::REG_HEADER_SECOND:   cfg_reg.header_second   <= cfg_data;
                lfbr_pkg::REG_LENGTH_POSITION: cfg_reg.length_position <= cfg_data[3:0];
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= char_event;
            byte_reg <= rx_byte;
        end
    end

    lfbr_frame_tracker #(
        .BUF_BYTES (BUF_BYTES)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (byte_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= result;
    end

    assign out_valid     = out_valid_reg;
    assign frame_end     = out_reg.frame_end;
    assign frame_status  = out_reg.frame_status;
    assign frame_len     = out_reg.frame_len;
    assign byte_position = out_reg.byte_position;

    // A classified character always shows up at the output
    a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("result lost after tracker step");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !step)
        else $error("output register overwritten while stalled");

    // Non-character events leave the output side alone
    a_skip_event: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !char_reg && !out_valid_reg |=> !out_valid_reg)
        else $error("result produced for non-character event");

endmodule
